[hdl/c4fsk_pkg.sv]
// Package: constants, types and helper functions of the C4FSK modulator with RRC filter.
`default_nettype none
package c4fsk_pkg;

    localparam int SAMPLES_PER_SYMBOL = 5;
    localparam int NUM_TAPS           = 34;
    localparam int DL_DEPTH           = NUM_TAPS - 1;
    localparam int TAP_W              = (NUM_TAPS > 2) ? $clog2(NUM_TAPS) : 1;
    localparam int REP_W              = $clog2(SAMPLES_PER_SYMBOL + 1);
    localparam int LEVEL_W            = 11;
    localparam int COEFF_W            = 16;
    localparam int PROD_W             = LEVEL_W + COEFF_W;
    localparam int ACC_W              = 32;
    localparam int SAMPLE_W           = 16;
    localparam int COEFF_LEN          = 34;
    localparam int COEFF_IDX_W        = $clog2(COEFF_LEN);
    localparam int TAP_EXT_W          = 7;

    typedef logic signed [LEVEL_W-1:0]  level_t;
    typedef logic signed [COEFF_W-1:0]  coeff_t;
    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [ACC_W-1:0]    acc_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_ACC,
        ST_OUT
    } state_t;

    localparam logic [1:0] DIBIT_POS_OUT = 2'b11;
    localparam logic [1:0] DIBIT_POS_IN  = 2'b10;
    localparam logic [1:0] DIBIT_NEG_IN  = 2'b00;
    localparam logic [1:0] DIBIT_NEG_OUT = 2'b01;

    localparam level_t LEVEL_HI_OUT = 11'sd809;
    localparam level_t LEVEL_HI_IN  = 11'sd269;
    localparam level_t LEVEL_LO_OUT = 11'sd405;
    localparam level_t LEVEL_LO_IN  = 11'sd135;

    localparam coeff_t RRC_COEFF [COEFF_LEN] = '{
        16'sd448,    16'sd0,      -16'sd622,   -16'sd954,   -16'sd619,   16'sd349,
        16'sd1391,   16'sd1704,   16'sd764,    -16'sd1182,  -16'sd3028,  -16'sd3279,
        -16'sd861,   16'sd4135,   16'sd10280,  16'sd15335,  16'sd17288,  16'sd15335,
        16'sd10280,  16'sd4135,   -16'sd861,   -16'sd3279,  -16'sd3028,  -16'sd1182,
        16'sd764,    16'sd1704,   16'sd1391,   16'sd349,    -16'sd619,   -16'sd954,
        -16'sd622,   16'sd0,      16'sd448,    16'sd0
    };

    // taps past the table read as zero
    function automatic coeff_t rrc_coeff(input logic [TAP_W-1:0] idx);
        logic [TAP_EXT_W-1:0] idx_ext;
        idx_ext = TAP_EXT_W'(idx);
        if (idx_ext < TAP_EXT_W'(COEFF_LEN))
            return RRC_COEFF[idx_ext[COEFF_IDX_W-1:0]];
        else
            return '0;
    endfunction

    function automatic level_t dibit_level(input logic [1:0] dibit, input logic low_dev);
        level_t outer;
        level_t inner;
        outer = low_dev ? LEVEL_LO_OUT : LEVEL_HI_OUT;
        inner = low_dev ? LEVEL_LO_IN  : LEVEL_HI_IN;
        unique case (dibit)
            DIBIT_POS_OUT: return outer;
            DIBIT_POS_IN:  return inner;
            DIBIT_NEG_IN:  return -inner;
            DIBIT_NEG_OUT: return -outer;
            default:       return -outer;
        endcase
    endfunction

    // arithmetic shift by 15, saturate to 16 bits
    function automatic sample_t sat_q15(input acc_t acc);
        if (!acc[ACC_W-1] && acc[ACC_W-2])
            return sample_t'(16'sh7FFF);
        else if (acc[ACC_W-1] && !acc[ACC_W-2])
            return sample_t'(16'sh8000);
        else
            return sample_t'(acc[ACC_W-2:15]);
    endfunction

endpackage
`default_nettype wire

[hdl/c4fsk_if.sv]
// Interfaces: byte input stream and filtered sample output stream.
`default_nettype none
interface c4fsk_byte_if
    import c4fsk_pkg::*;
;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface c4fsk_sample_if
    import c4fsk_pkg::*;
;
    logic    valid;
    logic    ready;
    sample_t sample;
    logic    last;

    modport source (output valid, output sample, output last, input ready);
    modport sink   (input valid, input sample, input last, output ready);
endinterface
`default_nettype wire

[hdl/c4fsk_symbol_map_rrc_fir.sv]
// Top level: C4FSK symbol mapper with iterative multiply-accumulate RRC FIR.
//
// byte_stream (sink) takes one data byte per transfer; sample_stream (source)
// returns 4*SAMPLES_PER_SYMBOL filtered Q15 samples for it (20 by default),
// the final one with last set. cfg_we/cfg_wdata write low_deviation; write
// it only while idle.
// Each sample is NUM_TAPS multiplies through one 16x11 multiplier, one
// accumulate step and one output load step.
// byte_stream.ready is high only between bytes.
// The output register holds one sample; the next sample is computed behind
// it, and the sequencer waits in the output load step while the sink stalls.
// Reset clears the delay line, low_deviation and all control state.
`default_nettype none
module c4fsk_symbol_map_rrc_fir
    import c4fsk_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cfg_we,
    input  wire logic          cfg_wdata,
    c4fsk_byte_if.sink         byte_stream,
    c4fsk_sample_if.source     sample_stream
);

    state_t                     state_reg, state_next;
    logic [7:0]                 byte_reg, byte_next;
    logic [1:0]                 sym_reg, sym_next;
    logic [REP_W-1:0]           rep_reg, rep_next;
    logic [TAP_W-1:0]           tap_reg, tap_next;
    logic                       prod_vld_reg, prod_vld_next;
    logic signed [PROD_W-1:0]   prod_reg, prod_next;
    acc_t                       acc_reg, acc_next;
    level_t                     dl_reg [DL_DEPTH];
    level_t                     dl_next [DL_DEPTH];
    logic                       out_vld_reg, out_vld_next;
    sample_t                    sample_reg, sample_next;
    logic                       last_reg, last_next;
    logic                       low_dev_reg;

    logic                       in_xfer;
    logic                       out_free;
    logic                       load_out;
    logic                       tap_last;
    logic                       sample_last;
    level_t                     level;
    level_t                     operand;
    logic signed [PROD_W-1:0]   coeff_ext;
    logic signed [PROD_W-1:0]   oper_ext;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (byte_stream.valid)
                    state_next = ST_MAC;
            end
            ST_MAC:
            begin
                if (tap_last)
                    state_next = ST_ACC;
            end
            ST_ACC:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_free)
                    state_next = sample_last ? ST_IDLE : ST_MAC;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        in_xfer     = byte_stream.valid && (state_reg == ST_IDLE);
        out_free    = !out_vld_reg || sample_stream.ready;
        load_out    = (state_reg == ST_OUT) && out_free;
        tap_last    = (tap_reg == TAP_W'(NUM_TAPS - 1));
        sample_last = (sym_reg == 2'd3) && (rep_reg == REP_W'(SAMPLES_PER_SYMBOL - 1));
    end

    assign byte_stream.ready    = (state_reg == ST_IDLE);
    assign sample_stream.valid  = out_vld_reg;
    assign sample_stream.sample = sample_reg;
    assign sample_stream.last   = last_reg;

    // datapath
    always_comb
    begin
        level     = dibit_level(byte_reg[7:6], low_dev_reg);
        operand   = tap_last ? level : dl_reg[0];
        coeff_ext = PROD_W'(rrc_coeff(tap_reg));
        oper_ext  = PROD_W'(operand);

        byte_next     = byte_reg;
        sym_next      = sym_reg;
        rep_next      = rep_reg;
        tap_next      = '0;
        prod_vld_next = 1'b0;
        prod_next     = prod_reg;
        acc_next      = acc_reg;
        dl_next       = dl_reg;
        out_vld_next  = out_vld_reg && !sample_stream.ready;
        sample_next   = sample_reg;
        last_next     = last_reg;

        if (prod_vld_reg)
            acc_next = acc_reg + ACC_W'(prod_reg);

        case (state_reg)
            ST_IDLE:
            begin
                acc_next = '0;
                if (in_xfer)
                begin
                    byte_next = byte_stream.data_byte;
                    sym_next  = '0;
                    rep_next  = '0;
                end
            end
            ST_MAC:
            begin
                prod_next     = coeff_ext * oper_ext;
                prod_vld_next = 1'b1;
                tap_next      = tap_last ? '0 : tap_reg + 1'b1;
                // rotate so the next tap sits at the head; on the newest tap shift in
                for (int i = 0; i < DL_DEPTH - 1; i++)
                    dl_next[i] = dl_reg[i + 1];
                dl_next[DL_DEPTH - 1] = tap_last ? level : dl_reg[0];
            end
            ST_OUT:
            begin
                if (load_out)
                begin
                    acc_next     = '0;
                    out_vld_next = 1'b1;
                    sample_next  = sat_q15(acc_reg);
                    last_next    = sample_last;
                    if (!sample_last)
                    begin
                        if (rep_reg == REP_W'(SAMPLES_PER_SYMBOL - 1))
                        begin
                            rep_next  = '0;
                            sym_next  = sym_reg + 1'b1;
                            byte_next = {byte_reg[5:0], 2'b00};
                        end
                        else
                        begin
                            rep_next = rep_reg + 1'b1;
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            byte_reg     <= '0;
            sym_reg      <= '0;
            rep_reg      <= '0;
            tap_reg      <= '0;
            prod_vld_reg <= 1'b0;
            prod_reg     <= '0;
            acc_reg      <= '0;
            out_vld_reg  <= 1'b0;
            sample_reg   <= '0;
            last_reg     <= 1'b0;
            low_dev_reg  <= 1'b0;
            for (int i = 0; i < DL_DEPTH; i++)
                dl_reg[i] <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            byte_reg     <= byte_next;
            sym_reg      <= sym_next;
            rep_reg      <= rep_next;
            tap_reg      <= tap_next;
            prod_vld_reg <= prod_vld_next;
            prod_reg     <= prod_next;
            acc_reg      <= acc_next;
            out_vld_reg  <= out_vld_next;
            sample_reg   <= sample_next;
            last_reg     <= last_next;
            dl_reg       <= dl_next;
            if (cfg_we)
                low_dev_reg <= cfg_wdata;
        end
    end

    a_busy_after_byte: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> !byte_stream.ready)
        else $error("ready high right after a byte transfer");

    a_tap_range: assert property (@(posedge clk) disable iff (!rst_n)
        tap_reg <= TAP_W'(NUM_TAPS - 1))
        else $error("tap counter out of range");

    a_last_ends_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (load_out && sample_last) |=> (state_reg == ST_IDLE) && out_vld_reg && last_reg)
        else $error("final sample did not end the byte");

    a_acc_has_product: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ACC) |-> prod_vld_reg)
        else $error("accumulate step without a pending product");

endmodule
`default_nettype wire
